// File: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high.
`define SFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define SFD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SFD_ASSERT_RST(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sfd_pkg.sv
`default_nettype none

package sfd_pkg;

   // Machine word width; the dividend and quotient are one bit narrower.
   localparam int WORD_BITS     = 64;
   localparam int DIVIDEND_BITS = WORD_BITS - 1;
   // One quotient bit is resolved per stage.
   localparam int STEPS         = DIVIDEND_BITS;
   // Storage slots: input stage, one per step, output register.
   localparam int SLOTS         = STEPS + 2;

   typedef logic signed [DIVIDEND_BITS-1:0] dividend_type;
   typedef logic signed [WORD_BITS-1:0]     divisor_type;
   typedef logic signed [DIVIDEND_BITS-1:0] quotient_type;
   typedef logic [DIVIDEND_BITS-1:0]        amag_type;
   typedef logic [WORD_BITS-1:0]            bmag_type;

   // Largest positive quotient; the only overflowing case saturates here.
   localparam quotient_type QUOT_MAX = {1'b0, {(DIVIDEND_BITS-1){1'b1}}};

endpackage

`default_nettype wire

// File: hw/rtl/sfd_if.sv
`default_nettype none

// Operand channel.
interface sfd_req_if;
   logic                 valid;
   logic                 ready;
   sfd_pkg::dividend_type dividend;
   sfd_pkg::divisor_type  divisor;

   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

// Result channel.
interface sfd_rsp_if;
   logic                 valid;
   logic                 ready;
   sfd_pkg::quotient_type quotient;
   logic                 divide_by_zero;

   modport source (output valid, output quotient, output divide_by_zero, input ready);
   modport sink   (input valid, input quotient, input divide_by_zero, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/signed_floor_divider.sv
// Signed floor divider.
// req_ch carries a signed dividend (WORD_BITS-1 bits) and a signed divisor
// (WORD_BITS bits); a beat is taken when valid and ready are both high.
// rsp_ch returns the quotient rounded toward minus infinity and a
// divide_by_zero flag; a zero divisor gives quotient zero with the flag set.
// The most negative dividend over minus one saturates to the largest quotient.
// Stages: the operand stage, one restoring subtract stage per quotient bit
// (WORD_BITS-1 of them, each a single WORD_BITS+1-wide compare and
// subtract), and the output register that applies the floor correction.
// Throughput: one beat per cycle unless stalled as below; results in order.
// Stall: while rsp_ch is held off, items keep moving into empty stages and
// req_ch stays ready until every stage up to the output register is full.
// Nothing is dropped or repeated.
// Reset (synchronous, active high) empties every stage and holds req_ch not
// ready; payload registers are not cleared.
`default_nettype none

module signed_floor_divider (
   input wire logic        clock,
   input wire logic        reset,
   sfd_req_if.sink         req_ch,
   sfd_rsp_if.source       rsp_ch
);

   localparam int W  = sfd_pkg::WORD_BITS;
   localparam int DB = sfd_pkg::DIVIDEND_BITS;
   localparam int NS = sfd_pkg::STEPS;

   // per-stage state: index 0 is the operand stage, NS the last step
   logic [NS:0]          valid_ff;
   logic [NS:0]          stage_ready;
   sfd_pkg::bmag_type    rem_ff  [0:NS];
   sfd_pkg::bmag_type    rem_in  [0:NS];
   sfd_pkg::amag_type    dq_ff   [0:NS];
   sfd_pkg::amag_type    dq_in   [0:NS];
   sfd_pkg::bmag_type    dmag_ff [0:NS];
   sfd_pkg::bmag_type    dmag_in [0:NS];
   logic [NS:0]          neg_ff;
   logic [NS:0]          neg_in;
   logic [NS:0]          dbz_ff;
   logic [NS:0]          dbz_in;

   logic                  out_ready;
   logic                  rsp_valid_ff;
   sfd_pkg::quotient_type quotient_ff;
   sfd_pkg::quotient_type quotient_in;
   logic                  dbz_out_ff;

   // operand stage: take magnitudes and note the signs
   logic a_neg;
   logic b_neg;
   assign a_neg = req_ch.dividend[DB-1];
   assign b_neg = req_ch.divisor[W-1];

   assign rem_in[0]  = '0;
   assign dq_in[0]   = a_neg ? (~req_ch.dividend + 1'b1) : req_ch.dividend;
   assign dmag_in[0] = b_neg ? (~req_ch.divisor + 1'b1) : req_ch.divisor;
   assign neg_in[0]  = a_neg ^ b_neg;
   assign dbz_in[0]  = (req_ch.divisor == '0);

   // restoring steps: shift in one dividend bit, subtract if it fits
   for (genvar s = 1; s <= NS; s++) begin : g_step
      logic [W:0] trial;
      logic [W:0] diff;
      logic       fits;

      assign trial = {rem_ff[s-1], dq_ff[s-1][DB-1]};
      assign diff  = trial - {1'b0, dmag_ff[s-1]};
      assign fits  = !diff[W];

      assign rem_in[s]  = fits ? diff[W-1:0] : trial[W-1:0];
      assign dq_in[s]   = {dq_ff[s-1][DB-2:0], fits};
      assign dmag_in[s] = dmag_ff[s-1];
      assign neg_in[s]  = neg_ff[s-1];
      assign dbz_in[s]  = dbz_ff[s-1];
   end

   // a stage may load when the output moves or any stage from it on is empty
   assign out_ready = !rsp_valid_ff || rsp_ch.ready;

   for (genvar s = 0; s <= NS; s++) begin : g_ready
      localparam logic [NS:0] LOW_MASK = (NS+1)'((65'd1 << s) - 65'd1);
      assign stage_ready[s] = out_ready || ((valid_ff | LOW_MASK) != '1);
   end

   // take no beat while reset is high
   assign req_ch.ready = stage_ready[0] && !reset;

   // advance the stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s <= NS; s++) begin
            if (stage_ready[s]) begin
               if (s == 0) begin
                  valid_ff[s] <= req_ch.valid;
               end else begin
                  valid_ff[s] <= valid_ff[s-1];
               end
            end
         end
      end
   end

   // advance the stage payloads
   always_ff @(posedge clock) begin
      for (int s = 0; s <= NS; s++) begin
         if (stage_ready[s]) begin
            rem_ff[s]  <= rem_in[s];
            dq_ff[s]   <= dq_in[s];
            dmag_ff[s] <= dmag_in[s];
            neg_ff[s]  <= neg_in[s];
            dbz_ff[s]  <= dbz_in[s];
         end
      end
   end

   // floor correction, saturation and the zero-divisor override
   logic                  rem_nz;
   sfd_pkg::amag_type     q_mag;
   sfd_pkg::amag_type     q_neg;

   assign rem_nz = |rem_ff[NS];
   assign q_mag  = dq_ff[NS];
   assign q_neg  = ~q_mag + {{(DB-1){1'b0}}, !rem_nz};

   always_comb begin
      if (dbz_ff[NS]) begin
         quotient_in = '0;
      end else if (neg_ff[NS]) begin
         quotient_in = q_neg;
      end else if (q_mag[DB-1]) begin
         quotient_in = sfd_pkg::QUOT_MAX;
      end else begin
         quotient_in = q_mag;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= valid_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         quotient_ff <= quotient_in;
         dbz_out_ff  <= dbz_ff[NS];
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.quotient       = quotient_ff;
   assign rsp_ch.divide_by_zero = dbz_out_ff;

endmodule

`default_nettype wire

// File: hw/rtl/sfd_checker.sv
`default_nettype none
`include "assert_macros.svh"

module sfd_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire sfd_pkg::quotient_type rsp_quotient,
   input wire logic                  rsp_divide_by_zero
);

   localparam int CNT_BITS = $clog2(sfd_pkg::SLOTS + 1);

   // count items held inside the block
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;
   logic                in_beat;
   logic                out_beat;

   assign in_beat  = req_valid && req_ready;
   assign out_beat = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (in_beat && !out_beat) begin
         count_in = count_ff + 1'b1;
      end else if (out_beat && !in_beat) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   `SFD_ASSERT_RST(a_reset_empty, clock, reset, !rsp_valid, "result offered after reset")
   `SFD_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_quotient) && $stable(rsp_divide_by_zero), "stalled result changed")
   `SFD_ASSERT_IMP(a_dbz_zero, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_quotient == '0, "zero divisor gave nonzero quotient")
   `SFD_ASSERT_IMP(a_no_invent, clock, reset, rsp_valid, count_ff != '0, "result with no item inside")
   `SFD_ASSERT_IMP(a_capacity, clock, reset, 1'b1, count_ff <= CNT_BITS'(sfd_pkg::SLOTS), "more items inside than stages")

endmodule

bind signed_floor_divider sfd_checker u_sfd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_quotient       (rsp_ch.quotient),
   .rsp_divide_by_zero (rsp_ch.divide_by_zero)
);

`default_nettype wire

// File: tb/tb_signed_floor_divider.sv
module tb_signed_floor_divider;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = sfd_pkg::WORD_BITS + 16;

   localparam sfd_pkg::dividend_type DIVIDEND_MAX =
      {1'b0, {(sfd_pkg::DIVIDEND_BITS-1){1'b1}}};
   localparam sfd_pkg::dividend_type DIVIDEND_MIN =
      {1'b1, {(sfd_pkg::DIVIDEND_BITS-1){1'b0}}};
   localparam sfd_pkg::divisor_type  DIVISOR_MAX  = {1'b0, {(sfd_pkg::WORD_BITS-1){1'b1}}};
   localparam sfd_pkg::divisor_type  DIVISOR_MIN  = {1'b1, {(sfd_pkg::WORD_BITS-1){1'b0}}};

   typedef struct {
      sfd_pkg::dividend_type dividend;
      sfd_pkg::divisor_type  divisor;
      sfd_pkg::quotient_type quotient;
      logic                  divide_by_zero;
   } quotient_entry_type;

   logic clock;
   logic reset;

   sfd_req_if req_ch ();
   sfd_rsp_if rsp_ch ();

   quotient_entry_type pending_quotients[$];
   int                 mismatch_count;
   int                 cycle_count;
   bit                 sender_gaps_on;
   bit                 rsp_stalls_on;

   signed_floor_divider u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Floor quotient of one operand pair, with the zero-divisor flag
   function automatic void floor_quotient(input sfd_pkg::dividend_type a_in,
                                          input sfd_pkg::divisor_type b_in,
                                          output sfd_pkg::quotient_type q,
                                          output logic dz);
      longint a;
      longint b;
      longint quo;
      longint rem;
      a   = a_in;
      b   = b_in;
      dz  = 1'b0;
      quo = 0;
      if (b == 0) begin
         dz = 1'b1;
      end else if (b == -1) begin
         // negation overflows only for the most negative dividend
         quo = (a_in == DIVIDEND_MIN) ? longint'(sfd_pkg::QUOT_MAX) : -a;
      end else begin
         quo = a / b;
         rem = a % b;
         if (rem != 0 && ((a < 0) != (b < 0))) quo = quo - 1;
      end
      q = quo[sfd_pkg::DIVIDEND_BITS-1:0];
   endfunction

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   // Drive one operand beat and hold it until taken; record the expected quotient
   task automatic send_operands(input sfd_pkg::dividend_type a, input sfd_pkg::divisor_type b);
      quotient_entry_type e;
      @(negedge clock);
      req_ch.valid    <= 1'b1;
      req_ch.dividend <= a;
      req_ch.divisor  <= b;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      e.dividend = a;
      e.divisor  = b;
      floor_quotient(a, b, e.quotient, e.divide_by_zero);
      pending_quotients.push_back(e);
   endtask

   // Drop valid and idle for a span set by n
   task automatic hold_operands(input int n);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic maybe_gap();
      if (sender_gaps_on && $urandom_range(0, 7) == 0) hold_operands($urandom_range(1, 17));
   endtask

   // Random operand pair drawn from several classes
   task automatic send_random_pair();
      logic [63:0]           w;
      longint                mag;
      longint                dmag;
      int                    width;
      sfd_pkg::dividend_type a;
      sfd_pkg::divisor_type  b;
      case ($urandom_range(0, 9))
         0, 1: begin
            w = rand_word();
            a = w[sfd_pkg::DIVIDEND_BITS-1:0];
            b = rand_word();
         end
         2, 3, 4: begin
            mag = longint'(rand_word() >> $urandom_range(2, 63));
            a = sfd_pkg::dividend_type'($urandom_range(0, 1) ? -mag : mag);
            mag = longint'(rand_word() >> $urandom_range(1, 63));
            b = $urandom_range(0, 1) ? -mag : mag;
         end
         5, 6: begin
            // exact multiple: no floor correction even with mixed signs
            width = $urandom_range(1, 30);
            dmag  = longint'(rand_word() >> (64 - width));
            if (dmag == 0) dmag = 1;
            mag   = longint'(rand_word() >> (3 + width));
            mag   = mag * dmag;
            a = sfd_pkg::dividend_type'($urandom_range(0, 1) ? -mag : mag);
            b = $urandom_range(0, 1) ? -dmag : dmag;
         end
         7: begin
            w = rand_word();
            a = w[sfd_pkg::DIVIDEND_BITS-1:0];
            case ($urandom_range(0, 4))
               0:       b = '0;
               1:       b = -1;
               2:       b = 1;
               3:       b = DIVISOR_MIN;
               default: b = DIVISOR_MAX;
            endcase
         end
         8: begin
            case ($urandom_range(0, 3))
               0:       a = DIVIDEND_MIN;
               1:       a = DIVIDEND_MAX;
               2:       a = -DIVIDEND_MAX;
               default: a = '0;
            endcase
            mag = longint'(rand_word() >> $urandom_range(0, 63));
            b = $urandom_range(0, 1) ? -mag : mag;
         end
         default: begin
            mag = longint'(rand_word() >> $urandom_range(2, 63));
            a = sfd_pkg::dividend_type'($urandom_range(0, 1) ? -mag : mag);
            b = $urandom_range(0, 1) ? -longint'($urandom_range(0, 3))
                                     : longint'($urandom_range(0, 3));
         end
      endcase
      send_operands(a, b);
   endtask

   // Result-side back-pressure in random bursts
   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (rsp_stalls_on && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin
      quotient_entry_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_quotients.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("unexpected result beat: quotient %0d divide_by_zero %0b",
                        rsp_ch.quotient, rsp_ch.divide_by_zero);
         end else begin
            e = pending_quotients.pop_front();
            if (rsp_ch.quotient !== e.quotient || rsp_ch.divide_by_zero !== e.divide_by_zero)
            begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("mismatch %0d / %0d: expected q %0d dz %0b, got q %0d dz %0b",
                           e.dividend, e.divisor, e.quotient, e.divide_by_zero,
                           rsp_ch.quotient, rsp_ch.divide_by_zero);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_operand_extremes();
      send_operands('0, 1);
      send_operands('0, -1);
      send_operands('0, DIVISOR_MIN);
      send_operands(DIVIDEND_MAX, 1);
      send_operands(DIVIDEND_MAX, -1);
      send_operands(-DIVIDEND_MAX, 1);
      send_operands(-DIVIDEND_MAX, -1);
      send_operands(DIVIDEND_MAX, DIVISOR_MAX);
      send_operands(DIVIDEND_MAX, DIVISOR_MIN);
      send_operands(-DIVIDEND_MAX, DIVISOR_MAX);
      send_operands(-DIVIDEND_MAX, DIVISOR_MIN);
      send_operands(-1, DIVISOR_MAX);
   endtask

   task automatic test_special_cases();
      // zero divisor
      send_operands(DIVIDEND_MAX, '0);
      send_operands(-1, '0);
      send_operands(DIVIDEND_MIN, '0);
      // most negative dividend: saturating negation and its neighbours
      send_operands(DIVIDEND_MIN, -1);
      send_operands(DIVIDEND_MIN, 1);
      send_operands(DIVIDEND_MIN, 2);
      send_operands(DIVIDEND_MIN, DIVISOR_MIN);
      // floor correction against truncation, inexact and exact
      send_operands(7, 2);
      send_operands(-7, 2);
      send_operands(7, -2);
      send_operands(-7, -2);
      send_operands(6, -3);
      send_operands(-6, 3);
   endtask

   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         // pick an idling mode per block of beats, none included
         if (i % 64 == 0) begin
            sender_gaps_on = $urandom_range(0, 1);
            rsp_stalls_on  = $urandom_range(0, 1);
         end
         maybe_gap();
         send_random_pair();
      end
   endtask

   // Hold off until the pipeline has emptied, then restart back to back
   task automatic test_drain_pause();
      hold_operands(1);
      while (pending_quotients.size() != 0) @(posedge clock);
      for (int i = 0; i < 16; i++) send_random_pair();
   endtask

   task automatic test_random_no_idle(input int count);
      sender_gaps_on = 1'b0;
      rsp_stalls_on  = 1'b0;
      for (int i = 0; i < count; i++) send_random_pair();
   endtask

   initial begin
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.dividend = '0;
      req_ch.divisor  = '0;
      mismatch_count  = 0;
      cycle_count     = 0;
      sender_gaps_on  = 1'b0;
      rsp_stalls_on   = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_operand_extremes();
      test_special_cases();
      test_random_mix(700);
      test_drain_pause();
      test_random_mix(680);
      test_random_no_idle(250);

      // drain and let the pipeline settle
      hold_operands(1);
      while (pending_quotients.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_quotients.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
